/* design/pfc_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the packet framer.
package pfc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [4:0] HEADER_BYTES = 5'd16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [31:0] crc_raw;
		logic [3:0] count;
		logic [63:0] payload;
		logic last;
	} frame_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/pfc_front.sv */
// Front end: gathers bytes into the open frame, runs the CRC and closes frames.
module pfc_front #(
	parameter int FRAME_LIMIT = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] data_byte,
	input  logic end_of_packet,
	output logic frame_push,
	output pfc_pkg::frame_t frame_out
);
	import pfc_pkg::*;

	localparam logic [3:0] LIMIT = 4'(FRAME_LIMIT);

	logic [2:0] fill_q;
	logic [31:0] crc_q;
	logic [63:0] buf_q;
	logic [31:0] crc_next;
	logic [63:0] buf_next;
	logic [3:0] count;
	logic done;

	always_comb begin
		crc_next = crc_byte(crc_q, data_byte);
		buf_next = buf_q | ({56'd0, data_byte} << {fill_q, 3'b000});
		count = {1'b0, fill_q} + 4'd1;
		done = (count >= LIMIT) || end_of_packet;
	end

	assign frame_push = accept && done;
	assign frame_out = '{crc_raw: crc_next, count: count, payload: buf_next,
		last: end_of_packet};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
			crc_q <= CRC_INIT;
			buf_q <= 64'd0;
		end else if (accept) begin
			if (done) begin
				fill_q <= 3'd0;
				crc_q <= CRC_INIT;
				buf_q <= 64'd0;
			end else begin
				fill_q <= count[2:0];
				crc_q <= crc_next;
				buf_q <= buf_next;
			end
		end
	end

endmodule

/* design/pfc_queue.sv */
// Short frame queue between the front end and the output stage.
module pfc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pfc_pkg::frame_t push_data,
	input  logic pop,
	output pfc_pkg::frame_t pop_data,
	output pfc_pkg::qstat_t stat
);
	import pfc_pkg::*;

	frame_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/pfc_back.sv */
// Back end: numbers frames, finishes the CRC and holds the result register.
module pfc_back (
	input  logic clk,
	input  logic arst_n,
	input  pfc_pkg::frame_t frame_in,
	input  logic queue_empty,
	output logic queue_pop,
	input  logic pop,
	output logic empty,
	output logic [31:0] frame_seq,
	output logic [31:0] frame_crc,
	output logic [3:0] payload_count,
	output logic [4:0] frame_length,
	output logic [63:0] payload_bits,
	output logic last_frame
);
	import pfc_pkg::*;

	logic valid_q;
	logic [31:0] seq_q;
	logic [31:0] seq_next;

	assign empty = !valid_q;
	assign queue_pop = (!valid_q || pop) && !queue_empty;
	assign seq_next = seq_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seq_q <= 32'd0;
		end else begin
			if (queue_pop) begin
				valid_q <= 1'b1;
				seq_q <= frame_in.last ? 32'd0 : seq_next;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (queue_pop) begin
			frame_seq <= seq_next;
			frame_crc <= ~frame_in.crc_raw;
			payload_count <= frame_in.count;
			frame_length <= HEADER_BYTES + {1'b0, frame_in.count};
			payload_bits <= frame_in.payload;
			last_frame <= frame_in.last;
		end
	end

endmodule

/* design/packet_framer_crc32.sv */
// Top level of the packet framer: byte input, frame queue and frame output.
//
// Channel   Handshake          Payload
// input     push / full        data_byte, end_of_packet
// result    pop / empty        frame_seq, frame_crc, payload_count, frame_length,
//                              payload_bits, last_frame
//
// One byte per cycle while full is low; the CRC byte update is combinational XOR logic.
// A closing byte's frame is written into the queue at the accepting edge and is loaded
// into the output register once the result register is free to take it from the queue.
// full rises only when the two-entry frame queue is full behind a stalled result.
// Reset clears the open frame, the queue and the sequence count at once.
module packet_framer_crc32 #(
	parameter int FRAME_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [7:0] data_byte,
	input  logic end_of_packet,
	output logic empty,
	input  logic pop,
	output logic [31:0] frame_seq,
	output logic [31:0] frame_crc,
	output logic [3:0] payload_count,
	output logic [4:0] frame_length,
	output logic [63:0] payload_bits,
	output logic last_frame
);
	import pfc_pkg::*;

	localparam int FRAME_LIMIT = (FRAME_BYTES < 1) ? 1 : ((FRAME_BYTES > 8) ? 8 : FRAME_BYTES);
	localparam logic [3:0] LIMIT = 4'(FRAME_LIMIT);

	logic accept;
	logic frame_push;
	logic queue_pop;
	frame_t front_frame;
	frame_t queue_frame;
	qstat_t qstat;

	assign full = qstat.full;
	assign accept = push && !full;

	pfc_front #(.FRAME_LIMIT(FRAME_LIMIT)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(data_byte),
		.end_of_packet(end_of_packet),
		.frame_push(frame_push),
		.frame_out(front_frame)
	);

	pfc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(frame_push),
		.push_data(front_frame),
		.pop(queue_pop),
		.pop_data(queue_frame),
		.stat(qstat)
	);

	pfc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(queue_frame),
		.queue_empty(qstat.empty),
		.queue_pop(queue_pop),
		.pop(pop),
		.empty(empty),
		.frame_seq(frame_seq),
		.frame_crc(frame_crc),
		.payload_count(payload_count),
		.frame_length(frame_length),
		.payload_bits(payload_bits),
		.last_frame(last_frame)
	);

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> frame_length == HEADER_BYTES + {1'b0, payload_count})
		else $error("frame length does not match payload count");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && payload_count < LIMIT) |-> last_frame)
		else $error("short frame without packet end");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (payload_count != 4'd0 && payload_count <= LIMIT))
		else $error("payload count out of range");

	a_eop_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_packet) |=> !qstat.empty)
		else $error("packet end did not close a frame");

endmodule

/* dv/tb_packet_framer_crc32.sv */
// Testbench for packet_framer_crc32: directed and random byte packets against a frame predictor.
`timescale 1ns / 1ps

module tb_packet_framer_crc32;
	import pfc_pkg::*;

	localparam int FRAME_LIMIT = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1350;

	typedef struct {
		logic [31:0] seq;
		logic [31:0] crc;
		logic [3:0] count;
		logic [4:0] length;
		logic [63:0] payload;
		logic last;
	} frame_exp_t;

	class frame_scoreboard;
		frame_exp_t pending[$];
		int errors;
		logic [31:0] seq_run;
		logic [31:0] crc_run;
		int fill;
		logic [63:0] pay_acc;

		function new();
			errors = 0;
			seq_run = '0;
			clear_frame();
		endfunction

		function void clear_frame();
			crc_run = CRC_INIT;
			fill = 0;
			pay_acc = '0;
		endfunction

		function logic [31:0] crc_update(logic [31:0] c, logic [7:0] d);
			logic [31:0] r;
			r = c ^ {24'd0, d};
			for (int i = 0; i < 8; i++) begin
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			end
			return r;
		endfunction

		function void note_byte(logic [7:0] d, logic eop);
			frame_exp_t f;
			int count;
			pay_acc = pay_acc | ({56'd0, d} << (8 * fill));
			crc_run = crc_update(crc_run, d);
			count = fill + 1;
			if (count >= FRAME_LIMIT || eop) begin
				seq_run = seq_run + 32'd1;
				f.seq = seq_run;
				f.crc = ~crc_run;
				f.count = count[3:0];
				f.length = HEADER_BYTES + 5'(count);
				f.payload = pay_acc;
				f.last = eop;
				pending.push_back(f);
				if (eop) begin
					seq_run = '0;
				end
				clear_frame();
			end else begin
				fill = count;
			end
		endfunction

		function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_frame(logic [31:0] seq, logic [31:0] crc, logic [3:0] count,
				logic [4:0] length, logic [63:0] payload, logic last);
			frame_exp_t f;
			if (pending.size() == 0) begin
				$display("%0t: unexpected frame expected none actual seq %h crc %h",
					$time, seq, crc);
				errors++;
				return;
			end
			f = pending.pop_front();
			cmp("frame_seq", 64'(f.seq), 64'(seq));
			cmp("frame_crc", 64'(f.crc), 64'(crc));
			cmp("payload_count", 64'(f.count), 64'(count));
			cmp("frame_length", 64'(f.length), 64'(length));
			cmp("payload_bits", f.payload, payload);
			cmp("last_frame", 64'(f.last), 64'(last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = '0;
	logic end_of_packet = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [31:0] frame_seq;
	logic [31:0] frame_crc;
	logic [3:0] payload_count;
	logic [4:0] frame_length;
	logic [63:0] payload_bits;
	logic last_frame;

	frame_scoreboard sb = new();
	int burst_left = 0;
	int idle_cycles = 0;

	packet_framer_crc32 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_packet(end_of_packet),
		.empty(empty),
		.pop(pop),
		.frame_seq(frame_seq),
		.frame_crc(frame_crc),
		.payload_count(payload_count),
		.frame_length(frame_length),
		.payload_bits(payload_bits),
		.last_frame(last_frame)
	);

	always #5 clk = ~clk;

	// drive one item, with a random gap between bursts
	task automatic send_byte(logic [7:0] d, logic eop);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		data_byte <= d;
		end_of_packet <= eop;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		sb.note_byte(d, eop);
	endtask

	task automatic send_packet(int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	// receiver: switches among random stall modes, each held for a random run
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		int run_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				sb.check_frame(frame_seq, frame_crc, payload_count, frame_length,
					payload_bits, last_frame);
			end
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			case (mode)
				0: begin
					pop <= 1'b1;
				end
				1: begin
					pop <= 1'($urandom_range(0, 1));
				end
				2: begin
					if (stall_left > 0) begin
						stall_left--;
						pop <= 1'b0;
					end else if (run_left > 0) begin
						run_left--;
						pop <= 1'b1;
					end else begin
						stall_left = $urandom_range(1, 30);
						run_left = $urandom_range(1, 10);
						pop <= 1'b0;
					end
				end
				default: begin
					pop <= ($urandom_range(0, 5) == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("packet_framer_crc32 test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int sent;
		int len;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte packets at the byte extremes
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// full frame closed by packet end
		for (int i = 0; i < 8; i++) begin
			send_byte(8'hFF, i == 7);
		end
		// full frame then one-byte tail
		for (int i = 0; i < 9; i++) begin
			send_byte((i % 2 == 0) ? 8'h00 : 8'hFF, i == 8);
		end
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h80, 1'b1);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: len = 8 * $urandom_range(1, 3);
				1: len = $urandom_range(30, 64);
				default: len = $urandom_range(1, 20);
			endcase
			send_packet(len);
			sent += len;
		end

		@(negedge clk);
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("packet_framer_crc32 test passed");
		end else begin
			$display("packet_framer_crc32 test failed");
		end
		$finish;
	end

endmodule

/* files.f */
design/pfc_pkg.sv
design/pfc_front.sv
design/pfc_queue.sv
design/pfc_back.sv
design/packet_framer_crc32.sv
dv/tb_packet_framer_crc32.sv
